// ===== rtl/hacm_pkg.sv =====
// Shared types, codes and constants of the head-angle to cursor mapper.
// No dependencies; every other file but hacm_check refers to it by scoped names.
`default_nettype none

package hacm_pkg;

    // Register indexes of the configuration port
    typedef enum logic [7:0] {
        REG_GAIN_YAW      = 8'd0,
        REG_GAIN_PITCH    = 8'd1,
        REG_DEAD_BAND     = 8'd2,
        REG_SMOOTH_WEIGHT = 8'd3,
        REG_ROLL_LIMIT    = 8'd4,
        REG_SCROLL_GAIN   = 8'd5,
        REG_INVERT_BITS   = 8'd6,
        REG_TRACKING_ON   = 8'd7
    } hacm_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DZ,
        ST_GAIN,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_FINISH
    } hacm_state_t;

    // Input item kinds carried in tuser
    localparam logic MODE_RECENTER = 1'b1;

    // Invert bit positions
    localparam int unsigned INV_X      = 0;
    localparam int unsigned INV_Y      = 1;
    localparam int unsigned INV_SCROLL = 2;

    // Angle and fixed-point constants
    localparam logic signed [17:0] HALF_TURN  = 18'sd46080;
    localparam logic signed [17:0] FULL_TURN  = 18'sd92160;
    localparam logic        [8:0]  WEIGHT_ONE = 9'd256;

    // Register reset values
    localparam logic [15:0] RST_GAIN_YAW      = 16'd11520;
    localparam logic [15:0] RST_GAIN_PITCH    = 16'd11520;
    localparam logic [15:0] RST_DEAD_BAND     = 16'd0;
    localparam logic [8:0]  RST_SMOOTH_WEIGHT = 9'd0;
    localparam logic [15:0] RST_ROLL_LIMIT    = 16'd5120;
    localparam logic [15:0] RST_SCROLL_GAIN   = 16'd26;
    localparam logic [2:0]  RST_INVERT_BITS   = 3'd2;
    localparam logic        RST_TRACKING_ON   = 1'b1;

    // Configuration as seen by the rest of the block
    typedef struct packed {
        logic [15:0] gain_yaw;
        logic [15:0] gain_pitch;
        logic [15:0] dead_band;
        logic [8:0]  smooth_weight;
        logic [15:0] roll_limit;
        logic [15:0] scroll_gain;
        logic [2:0]  invert_bits;
        logic        tracking_on;
    } hacm_cfg_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load_ref;
        logic load_item;
        logic dz;
        logic gain;
        logic blend_a;
        logic blend_b;
        logic finish;
    } hacm_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/hacm_cfg.sv =====
// Configuration register file of the mapper.
// Depends on hacm_pkg for register indexes, reset values and the config struct.
`default_nettype none

module hacm_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    output hacm_pkg::hacm_cfg_t    cfg,
    output logic                   trk_clear
);

    hacm_pkg::hacm_cfg_t cfg_reg;
    hacm_pkg::hacm_cfg_t cfg_next;
    logic                wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    // Writing tracking off drops the stored reference
    assign trk_clear = wr && (cfg_index == hacm_pkg::REG_TRACKING_ON) && !cfg_data[0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (cfg_index)
                hacm_pkg::REG_GAIN_YAW:      cfg_next.gain_yaw      = cfg_data;
                hacm_pkg::REG_GAIN_PITCH:    cfg_next.gain_pitch    = cfg_data;
                hacm_pkg::REG_DEAD_BAND:     cfg_next.dead_band     = cfg_data;
                hacm_pkg::REG_SMOOTH_WEIGHT: cfg_next.smooth_weight = cfg_data[8:0];
                hacm_pkg::REG_ROLL_LIMIT:    cfg_next.roll_limit    = cfg_data;
                hacm_pkg::REG_SCROLL_GAIN:   cfg_next.scroll_gain   = cfg_data;
                hacm_pkg::REG_INVERT_BITS:   cfg_next.invert_bits   = cfg_data[2:0];
                hacm_pkg::REG_TRACKING_ON:   cfg_next.tracking_on   = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_yaw      <= hacm_pkg::RST_GAIN_YAW;
            cfg_reg.gain_pitch    <= hacm_pkg::RST_GAIN_PITCH;
            cfg_reg.dead_band     <= hacm_pkg::RST_DEAD_BAND;
            cfg_reg.smooth_weight <= hacm_pkg::RST_SMOOTH_WEIGHT;
            cfg_reg.roll_limit    <= hacm_pkg::RST_ROLL_LIMIT;
            cfg_reg.scroll_gain   <= hacm_pkg::RST_SCROLL_GAIN;
            cfg_reg.invert_bits   <= hacm_pkg::RST_INVERT_BITS;
            cfg_reg.tracking_on   <= hacm_pkg::RST_TRACKING_ON;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hacm_ctrl.sv =====
// Sequencer of the mapper: accepts items, tracks the reference flag and
// steps the datapath. Depends on hacm_pkg for states and the command struct.
`default_nettype none

module hacm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              mode,
    input  wire logic              tracking_on,
    input  wire logic              trk_clear,
    input  wire logic              out_free,
    output hacm_pkg::hacm_cmd_t    cmd
);

    hacm_pkg::hacm_state_t state_reg;
    hacm_pkg::hacm_state_t state_next;
    logic                  have_ref_reg;
    logic                  have_ref_next;
    logic                  accept;

    assign s_tready = (state_reg == hacm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hacm_pkg::ST_IDLE;
            have_ref_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            have_ref_reg <= have_ref_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        have_ref_next = have_ref_reg;
        cmd           = '0;
        unique case (state_reg)
            hacm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (mode == hacm_pkg::MODE_RECENTER)
                    begin
                        have_ref_next = 1'b0;
                    end
                    else if (!tracking_on)
                    begin
                        have_ref_next = have_ref_reg;
                    end
                    else if (!have_ref_reg)
                    begin
                        cmd.load_ref  = 1'b1;
                        have_ref_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = hacm_pkg::ST_DZ;
                    end
                end
            end
            hacm_pkg::ST_DZ:
            begin
                cmd.dz     = 1'b1;
                state_next = hacm_pkg::ST_GAIN;
            end
            hacm_pkg::ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = hacm_pkg::ST_BLEND_A;
            end
            hacm_pkg::ST_BLEND_A:
            begin
                cmd.blend_a = 1'b1;
                state_next  = hacm_pkg::ST_BLEND_B;
            end
            hacm_pkg::ST_BLEND_B:
            begin
                cmd.blend_b = 1'b1;
                state_next  = hacm_pkg::ST_FINISH;
            end
            hacm_pkg::ST_FINISH:
            begin
                // Hold until the output register can take the item
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = hacm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hacm_pkg::ST_IDLE;
            end
        endcase
        if (trk_clear)
        begin
            have_ref_next = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hacm_lane.sv =====
// One motion axis of the mapper: gain, smoothing blend and sub-pixel
// accumulation on a single shared multiplier. Depends on hacm_pkg.
`default_nettype none

module hacm_lane (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hacm_pkg::hacm_cmd_t cmd,
    input  wire logic signed [17:0]  dz,
    input  wire logic        [15:0]  gain,
    input  wire logic        [8:0]   weight,
    output logic signed      [15:0]  move
);

    logic signed [33:0] m_reg;
    logic signed [33:0] m_next;
    logic signed [43:0] acc_reg;
    logic signed [43:0] acc_next;
    logic signed [33:0] smooth_reg;
    logic signed [33:0] smooth_next;
    logic signed [16:0] frac_reg;
    logic signed [16:0] frac_next;

    logic signed [33:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [50:0] prod;
    logic        [8:0]  inv_weight;

    logic signed [33:0] s_val;
    logic signed [34:0] sum;
    logic signed [18:0] q_floor;
    logic signed [18:0] q_trunc;
    logic               adj;

    assign inv_weight = 9'(hacm_pkg::WEIGHT_ONE - weight);

    // Operand select for the shared multiplier
    always_comb
    begin
        priority if (cmd.blend_a)
        begin
            mul_a = m_reg;
            mul_b = $signed({8'b0, inv_weight});
        end
        else if (cmd.blend_b)
        begin
            mul_a = smooth_reg;
            mul_b = $signed({8'b0, weight});
        end
        else
        begin
            mul_a = 34'(dz);
            mul_b = $signed({1'b0, gain});
        end
    end

    assign prod = mul_a * mul_b;

    // Floor by 256, then split into whole pixels truncated toward zero
    assign s_val   = acc_reg[41:8];
    assign sum     = 35'(s_val) + 35'(frac_reg);
    assign q_floor = sum[34:16];
    assign adj     = sum[34] && (sum[15:0] != 16'd0);
    assign q_trunc = q_floor + $signed({18'b0, adj});

    always_comb
    begin
        if (q_trunc > 19'sd32767)
        begin
            move = 16'sh7FFF;
        end
        else if (q_trunc < -19'sd32768)
        begin
            move = -16'sh8000;
        end
        else
        begin
            move = q_trunc[15:0];
        end
    end

    always_comb
    begin
        m_next      = m_reg;
        acc_next    = acc_reg;
        smooth_next = smooth_reg;
        frac_next   = frac_reg;
        if (cmd.gain)
        begin
            m_next = prod[33:0];
        end
        if (cmd.blend_a)
        begin
            acc_next = prod[43:0];
        end
        if (cmd.blend_b)
        begin
            acc_next = 44'(acc_reg + prod[43:0]);
        end
        if (cmd.finish)
        begin
            smooth_next = s_val;
            frac_next   = {adj, sum[15:0]};
        end
        if (cmd.load_ref)
        begin
            frac_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
            frac_reg   <= '0;
        end
        else
        begin
            smooth_reg <= smooth_next;
            frac_reg   <= frac_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hacm_dp.sv =====
// Datapath of the mapper: reference angles, deltas with wrap and deadzone,
// scroll step, two axis lanes and the output register. Depends on hacm_pkg
// and hacm_lane.
`default_nettype none

module hacm_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hacm_pkg::hacm_cmd_t cmd,
    input  wire hacm_pkg::hacm_cfg_t cfg,
    input  wire logic signed [16:0]  roll_angle,
    input  wire logic signed [16:0]  pitch_angle,
    input  wire logic signed [16:0]  yaw_angle,
    input  wire logic                out_ready,
    output logic                     out_free,
    output logic                     out_valid,
    output logic signed [15:0]       move_x,
    output logic signed [15:0]       move_y,
    output logic signed [15:0]       scroll_step,
    output logic                     move_flag,
    output logic                     scroll_flag
);

    logic signed [16:0] ref_yaw_reg;
    logic signed [16:0] ref_yaw_next;
    logic signed [16:0] ref_pitch_reg;
    logic signed [16:0] ref_pitch_next;

    logic signed [17:0] dyaw_reg;
    logic signed [17:0] dpitch_reg;
    logic signed [16:0] roll_reg;
    logic signed [17:0] dz_x_reg;
    logic signed [17:0] dz_y_reg;
    logic        [16:0] excess_reg;
    logic               scroll_neg_reg;
    logic signed [15:0] scroll_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] move_x_reg;
    logic signed [15:0] move_y_reg;
    logic signed [15:0] scroll_out_reg;
    logic               move_flag_reg;
    logic               scroll_flag_reg;

    logic signed [17:0] dy_a;
    logic signed [17:0] dy_b;
    logic signed [17:0] sd_x;
    logic signed [17:0] sd_y;
    logic        [16:0] roll_mag;
    logic               roll_pos;
    logic        [32:0] scroll_prod;
    logic        [14:0] scroll_mag;
    logic        [8:0]  weight;
    logic signed [15:0] lane_x_move;
    logic signed [15:0] lane_y_move;

    function automatic logic signed [17:0] soft_dead(
        input logic signed [17:0] d,
        input logic        [15:0] db
    );
        logic [17:0]        mag;
        logic [17:0]        rem;
        logic signed [17:0] res;
        mag = d[17] ? 18'(-d) : 18'(d);
        rem = mag - {2'b0, db};
        if (mag < {2'b0, db})
        begin
            res = '0;
        end
        else
        begin
            res = d[17] ? -$signed(rem) : $signed(rem);
        end
        return res;
    endfunction

    // Yaw wraps into a half turn either way, once in each direction
    always_comb
    begin
        dy_a = (dyaw_reg > hacm_pkg::HALF_TURN) ? 18'(dyaw_reg - hacm_pkg::FULL_TURN)
                                                : dyaw_reg;
        dy_b = (dy_a < -hacm_pkg::HALF_TURN) ? 18'(dy_a + hacm_pkg::FULL_TURN) : dy_a;
    end

    assign sd_x     = soft_dead(dy_b, cfg.dead_band);
    assign sd_y     = soft_dead(dpitch_reg, cfg.dead_band);
    assign roll_mag = roll_reg[16] ? 17'(-roll_reg) : 17'(roll_reg);
    assign roll_pos = !roll_reg[16] && (roll_reg != 17'sd0);

    assign scroll_prod = excess_reg * cfg.scroll_gain;
    assign scroll_mag  = (scroll_prod[32:16] > 17'd32767) ? 15'h7FFF : scroll_prod[30:16];

    assign weight = (cfg.smooth_weight > hacm_pkg::WEIGHT_ONE) ? hacm_pkg::WEIGHT_ONE
                                                              : cfg.smooth_weight;

    hacm_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .dz     (dz_x_reg),
        .gain   (cfg.gain_yaw),
        .weight (weight),
        .move   (lane_x_move)
    );

    hacm_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .dz     (dz_y_reg),
        .gain   (cfg.gain_pitch),
        .weight (weight),
        .move   (lane_y_move)
    );

    always_comb
    begin
        ref_yaw_next   = ref_yaw_reg;
        ref_pitch_next = ref_pitch_reg;
        if (cmd.load_ref || cmd.load_item)
        begin
            ref_yaw_next   = yaw_angle;
            ref_pitch_next = pitch_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_yaw_reg   <= '0;
            ref_pitch_reg <= '0;
        end
        else
        begin
            ref_yaw_reg   <= ref_yaw_next;
            ref_pitch_reg <= ref_pitch_next;
        end
    end

    // Working registers of one item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            dyaw_reg   <= 18'(yaw_angle) - 18'(ref_yaw_reg);
            dpitch_reg <= 18'(pitch_angle) - 18'(ref_pitch_reg);
            roll_reg   <= roll_angle;
        end
        if (cmd.dz)
        begin
            dz_x_reg       <= cfg.invert_bits[hacm_pkg::INV_X] ? 18'(-sd_x) : sd_x;
            dz_y_reg       <= cfg.invert_bits[hacm_pkg::INV_Y] ? 18'(-sd_y) : sd_y;
            excess_reg     <= (roll_mag > {1'b0, cfg.roll_limit})
                              ? 17'(roll_mag - {1'b0, cfg.roll_limit}) : 17'd0;
            scroll_neg_reg <= (roll_pos == cfg.invert_bits[hacm_pkg::INV_SCROLL]);
        end
        if (cmd.gain)
        begin
            scroll_reg <= scroll_neg_reg ? 16'(-$signed({1'b0, scroll_mag}))
                                         : $signed({1'b0, scroll_mag});
        end
    end

    // Output register
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            move_x_reg      <= lane_x_move;
            move_y_reg      <= lane_y_move;
            scroll_out_reg  <= scroll_reg;
            move_flag_reg   <= (lane_x_move != 16'sd0) || (lane_y_move != 16'sd0);
            scroll_flag_reg <= (scroll_reg != 16'sd0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign move_x      = move_x_reg;
    assign move_y      = move_y_reg;
    assign scroll_step = scroll_out_reg;
    assign move_flag   = move_flag_reg;
    assign scroll_flag = scroll_flag_reg;

endmodule

`default_nettype wire

// ===== rtl/head_angle_to_cursor_mapper.sv =====
// Top level of the head-angle to cursor mapper: stream ports, configuration
// port, sequencer and datapath. Depends on hacm_pkg, hacm_cfg, hacm_ctrl, hacm_dp.
//
// The block turns head orientation items (roll, pitch, yaw in signed
// 1/256-degree units) into relative cursor moves and scroll steps. The first
// sample after reset, after a recenter item (tuser set) or after a write of
// tracking_on to zero only stores the reference angles and gives no result;
// recenter items and samples taken while tracking is off give no result either.
// Every later sample gives exactly one result, even when all moves are zero. A
// sample that produces a result occupies the block from the accept cycle through
// deadzone and wrap, gain, two blend steps on the shared per-axis multiplier, and
// the accumulate step that loads the output register; a new item is taken in the
// cycle after that. The accumulate step waits while the output register still
// holds an item that has not been taken. Items that give no result leave the
// block ready again in the next cycle. Configuration writes are always ready and
// take effect at once; write them only while no item is in flight.
`default_nettype none

module head_angle_to_cursor_mapper (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // roll_angle[16:0], pitch_angle[33:17],
                                        // yaw_angle[50:34], zero fill[55:51]
    input  wire logic [0:0]  s_tuser,   // mode[0]: 1 recenter, 0 sample

    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // move_x[15:0], move_y[31:16],
                                        // scroll_step[47:32]
    output logic [1:0]       m_tuser,   // move_flag[0], scroll_flag[1]

    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    hacm_pkg::hacm_cfg_t cfg;
    hacm_pkg::hacm_cmd_t cmd;
    logic                trk_clear;
    logic                out_free;
    logic signed [15:0]  move_x;
    logic signed [15:0]  move_y;
    logic signed [15:0]  scroll_step;
    logic                move_flag;
    logic                scroll_flag;

    // Register file; a write of tracking off drops the reference
    hacm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .trk_clear (trk_clear)
    );

    // Sequencer: decides per item whether to store a reference, run the datapath or do neither
    hacm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .mode        (s_tuser[0]),
        .tracking_on (cfg.tracking_on),
        .trk_clear   (trk_clear),
        .out_free    (out_free),
        .cmd         (cmd)
    );

    // Datapath: angles are taken straight from the port in the accept cycle
    hacm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .roll_angle  ($signed(s_tdata[16:0])),
        .pitch_angle ($signed(s_tdata[33:17])),
        .yaw_angle   ($signed(s_tdata[50:34])),
        .out_ready   (m_tready),
        .out_free    (out_free),
        .out_valid   (m_tvalid),
        .move_x      (move_x),
        .move_y      (move_y),
        .scroll_step (scroll_step),
        .move_flag   (move_flag),
        .scroll_flag (scroll_flag)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {scroll_step, move_y, move_x};
    assign m_tuser = {scroll_flag, move_flag};

endmodule

`default_nettype wire

// ===== rtl/hacm_check.sv =====
// Port-level checks of the head-angle to cursor mapper, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module hacm_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Move flag follows the move fields
    a_move_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tdata[31:0] != 32'd0)))
        else $error("move_flag does not match move_x/move_y");

    // Scroll flag follows the scroll field
    a_scroll_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1] == (m_tdata[47:32] != 16'd0)))
        else $error("scroll_flag does not match scroll_step");

    // Scroll magnitude is saturated symmetrically
    a_scroll_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:32] != 16'h8000))
        else $error("scroll_step outside the symmetric range");

    // A recenter item starts no work
    a_recenter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> s_tready)
        else $error("recenter item kept the block busy");

endmodule

bind head_angle_to_cursor_mapper hacm_check u_hacm_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
